// ===== design/cvmb_pkg.sv =====
`default_nettype none

package cvmb_pkg;

  typedef enum logic [1:0] {
    MODE_INIT        = 2'd0,
    MODE_STANDBY     = 2'd1,
    MODE_DISCHARGING = 2'd2,
    MODE_FAULT       = 2'd3
  } mode_t;

  // How the output stage treats soc, over and under for one result
  typedef enum logic [1:0] {
    RES_KEEP = 2'd0,
    RES_CALC = 2'd1,
    RES_ZERO = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    REG_OVER_LIMIT  = 2'd0,
    REG_UNDER_LIMIT = 2'd1,
    REG_MAX_TRIES   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [12:0] voltage;
    mode_t       mode;
    logic        toggle;
    logic        fault;
    res_kind_t   kind;
  } result_t;

  localparam int MV_W = 13;

  // Exact floor division of a sum below 2**19 by a divisor up to 64:
  // q = (sum * ceil(2**DIV_SHIFT / d)) >> DIV_SHIFT
  localparam int DIV_SHIFT = 25;
  localparam int RECIP_W   = DIV_SHIFT + 1;

  localparam logic [12:0] SOC_MULT   = 13'd5461;
  localparam int          SOC_SHIFT  = 16;
  localparam logic [10:0] SOC_OFFSET = 11'd250;

  localparam logic [12:0] OVER_RESET  = 13'd4200;
  localparam logic [12:0] UNDER_RESET = 13'd3000;
  localparam logic [3:0]  TRIES_RESET = 4'd3;
  localparam logic [3:0]  TRIES_MAX   = 4'd15;

endpackage

`default_nettype wire

// ===== design/cell_voltage_monitor_balancer_core.sv =====
// Pipeline: input register, state update stage, output register.
// A result moves from the input register through the state update stage to the output register; one item per cycle
// sustained, limited only by the output handshake.
// The state update stage holds one multiply by the averaging reciprocal.
// Synchronous reset returns the mode to init, clears all measurement state
// and restores the threshold registers to their defaults.
`default_nettype none

module cell_voltage_monitor_balancer_core #(
  parameter int SAMPLES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [12:0] sample_mv,
  input  wire logic [12:0] delta_mv,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [12:0]      voltage_mv,
  output logic [9:0]       soc,
  output logic [12:0]      over_mv,
  output logic [12:0]      under_mv,
  output logic [1:0]       cell_mode_out,
  output logic             toggle_balance,
  output logic             fault
);

  localparam int SumW   = $clog2(SAMPLES * 8191 + 1);
  localparam int CntW   = $clog2(SAMPLES + 1);
  localparam int RecipW = cvmb_pkg::RECIP_W;
  localparam int ProdW  = SumW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((1 << cvmb_pkg::DIV_SHIFT) + SAMPLES - 1) / SAMPLES);
  localparam logic [CntW-1:0] CntLast = CntW'(SAMPLES);

  // configuration
  logic [12:0] over_limit;
  logic [12:0] under_limit;
  logic [3:0]  max_attempts;

  // input register
  logic        s1_valid;
  logic        s1_op;
  logic [12:0] s1_sample;
  logic [12:0] s1_delta;

  // measurement state
  cvmb_pkg::mode_t cell_mode;
  logic [SumW-1:0] sample_sum;
  logic [CntW-1:0] good_samples;
  logic [3:0]      failed_tries;
  logic [12:0]     cell_voltage;
  logic [12:0]     discharge_target;

  // reported amounts, updated in the output stage
  logic [9:0]  soc_value;
  logic [12:0] over_amount;
  logic [12:0] under_amount;

  // middle stage
  logic              s2_valid;
  cvmb_pkg::result_t s2_res;

  // handshake control
  logic out_adv;
  logic s2_free;
  logic s1_fire;

  assign out_adv  = !out_valid || out_ready;
  assign s2_free  = !s2_valid || out_adv;
  assign s1_fire  = s1_valid && s2_free;
  assign in_ready = !s1_valid || s1_fire;

  // state update logic
  cvmb_pkg::mode_t   mode_next;
  logic [SumW-1:0]   sum_next;
  logic [CntW-1:0]   cnt_next;
  logic [3:0]        tries_next;
  logic [12:0]       voltage_next;
  logic [12:0]       target_next;
  logic              res_valid;
  cvmb_pkg::result_t res;
  logic [SumW-1:0]   sum_add;
  logic [CntW-1:0]   cnt_add;
  logic [3:0]        tries_inc;
  logic [ProdW-1:0]  avg_prod;
  logic [12:0]       avg;
  logic [12:0]       target_cmd;

  always_comb begin
    sum_add    = sample_sum + SumW'(s1_sample);
    cnt_add    = good_samples + CntW'(1);
    tries_inc  = (failed_tries < cvmb_pkg::TRIES_MAX) ? failed_tries + 4'd1 : failed_tries;
    avg_prod   = ProdW'(sum_add) * ProdW'(Recip);
    avg        = avg_prod[cvmb_pkg::DIV_SHIFT +: cvmb_pkg::MV_W];
    target_cmd = (cell_voltage > s1_delta) ? cell_voltage - s1_delta : 13'd0;
  end

  always_comb begin
    mode_next    = cell_mode;
    sum_next     = sample_sum;
    cnt_next     = good_samples;
    tries_next   = failed_tries;
    voltage_next = cell_voltage;
    target_next  = discharge_target;
    res_valid    = 1'b0;
    res.voltage  = cell_voltage;
    res.mode     = cell_mode;
    res.toggle   = 1'b0;
    res.fault    = 1'b0;
    res.kind     = cvmb_pkg::RES_KEEP;
    if (s1_op) begin
      // discharge command: new target, restart the measurement
      target_next = target_cmd;
      sum_next    = '0;
      cnt_next    = '0;
      tries_next  = 4'd0;
      res_valid   = 1'b1;
      if (cell_voltage > target_cmd) begin
        mode_next  = cvmb_pkg::MODE_DISCHARGING;
        res.toggle = 1'b1;
      end else begin
        mode_next = cvmb_pkg::MODE_STANDBY;
      end
      res.mode = mode_next;
    end else if (s1_sample == 13'd0) begin
      tries_next = tries_inc;
      if (tries_inc >= max_attempts) begin
        mode_next    = cvmb_pkg::MODE_FAULT;
        voltage_next = 13'd0;
        sum_next     = '0;
        cnt_next     = '0;
        tries_next   = 4'd0;
        res_valid    = 1'b1;
        res.voltage  = 13'd0;
        res.mode     = cvmb_pkg::MODE_FAULT;
        res.fault    = 1'b1;
        res.kind     = cvmb_pkg::RES_ZERO;
      end
    end else begin
      tries_next = 4'd0;
      if (cnt_add < CntLast) begin
        sum_next = sum_add;
        cnt_next = cnt_add;
      end else begin
        sum_next     = '0;
        cnt_next     = '0;
        voltage_next = avg;
        res_valid    = 1'b1;
        res.voltage  = avg;
        if (cell_mode == cvmb_pkg::MODE_DISCHARGING) begin
          if (avg > discharge_target) begin
            res.toggle = 1'b1;
          end else begin
            mode_next = cvmb_pkg::MODE_STANDBY;
          end
        end else begin
          res.kind = cvmb_pkg::RES_CALC;
        end
        res.mode = mode_next;
      end
    end
  end

  // output stage arithmetic
  logic [25:0] soc_prod;
  logic [10:0] soc_wide;
  logic [9:0]  soc_next;
  logic [12:0] over_next;
  logic [12:0] under_next;

  always_comb begin
    soc_prod = 26'(s2_res.voltage) * 26'(cvmb_pkg::SOC_MULT);
    soc_wide = {1'b0, soc_prod[cvmb_pkg::SOC_SHIFT +: 10]} - cvmb_pkg::SOC_OFFSET;
    case (s2_res.kind)
      cvmb_pkg::RES_CALC: begin
        soc_next   = soc_wide[9:0];
        over_next  = (s2_res.voltage >= over_limit) ? s2_res.voltage - over_limit : 13'd0;
        under_next = (s2_res.voltage < under_limit) ? under_limit - s2_res.voltage : 13'd0;
      end
      cvmb_pkg::RES_ZERO: begin
        soc_next   = 10'd0;
        over_next  = 13'd0;
        under_next = 13'd0;
      end
      default: begin
        soc_next   = soc_value;
        over_next  = over_amount;
        under_next = under_amount;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      over_limit   <= cvmb_pkg::OVER_RESET;
      under_limit  <= cvmb_pkg::UNDER_RESET;
      max_attempts <= cvmb_pkg::TRIES_RESET;
    end else if (cfg_we) begin
      case (cvmb_pkg::reg_index_t'(cfg_index))
        cvmb_pkg::REG_OVER_LIMIT:  over_limit   <= cfg_data;
        cvmb_pkg::REG_UNDER_LIMIT: under_limit  <= cfg_data;
        cvmb_pkg::REG_MAX_TRIES:   max_attempts <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op     <= op;
      s1_sample <= sample_mv;
      s1_delta  <= delta_mv;
    end
  end

  // measurement state and middle stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_mode        <= cvmb_pkg::MODE_INIT;
      sample_sum       <= '0;
      good_samples     <= '0;
      failed_tries     <= 4'd0;
      cell_voltage     <= 13'd0;
      discharge_target <= 13'd0;
      s2_valid         <= 1'b0;
    end else begin
      if (s1_fire) begin
        cell_mode        <= mode_next;
        sample_sum       <= sum_next;
        good_samples     <= cnt_next;
        failed_tries     <= tries_next;
        cell_voltage     <= voltage_next;
        discharge_target <= target_next;
        s2_valid         <= res_valid;
      end else if (out_adv) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_res <= res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      soc_value    <= 10'd0;
      over_amount  <= 13'd0;
      under_amount <= 13'd0;
    end else if (out_adv) begin
      out_valid <= s2_valid;
      if (s2_valid) begin
        soc_value    <= soc_next;
        over_amount  <= over_next;
        under_amount <= under_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_valid) begin
      voltage_mv     <= s2_res.voltage;
      soc            <= soc_next;
      over_mv        <= over_next;
      under_mv       <= under_next;
      cell_mode_out  <= s2_res.mode;
      toggle_balance <= s2_res.toggle;
      fault          <= s2_res.fault;
    end
  end

endmodule

`default_nettype wire
